>>> rtl/rfp_pkg.sv
package rfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CodeW  = 2;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned DataW  = 48;

  // parse phases
  localparam logic [PhaseW-1:0] PH_IDLE      = 3'd0;
  localparam logic [PhaseW-1:0] PH_LEN       = 3'd1;
  localparam logic [PhaseW-1:0] PH_DATA      = 3'd2;
  localparam logic [PhaseW-1:0] PH_DATA_CSUM = 3'd3;
  localparam logic [PhaseW-1:0] PH_ERR_BYTE  = 3'd4;
  localparam logic [PhaseW-1:0] PH_ERR_CSUM  = 3'd5;

  // frame kinds
  localparam logic [CodeW-1:0] KIND_ACK  = 2'd0;
  localparam logic [CodeW-1:0] KIND_DATA = 2'd1;
  localparam logic [CodeW-1:0] KIND_NACK = 2'd2;
  localparam logic [CodeW-1:0] KIND_ERR  = 2'd3;

  // frame status
  localparam logic [CodeW-1:0] ST_OK      = 2'd0;
  localparam logic [CodeW-1:0] ST_CSUM    = 2'd1;
  localparam logic [CodeW-1:0] ST_LONG    = 2'd2;
  localparam logic [CodeW-1:0] ST_UNKNOWN = 2'd3;

  // register indexes
  localparam logic [IdxW-1:0] REG_ACK      = 3'd0;
  localparam logic [IdxW-1:0] REG_ACK_DATA = 3'd1;
  localparam logic [IdxW-1:0] REG_NACK     = 3'd2;
  localparam logic [IdxW-1:0] REG_ACK_ERR  = 3'd3;
  localparam logic [IdxW-1:0] REG_MAX_LEN  = 3'd4;

  localparam logic [ByteW-1:0] RST_ACK      = 8'd6;
  localparam logic [ByteW-1:0] RST_ACK_DATA = 8'd7;
  localparam logic [ByteW-1:0] RST_NACK     = 8'd21;
  localparam logic [ByteW-1:0] RST_ACK_ERR  = 8'd8;
  localparam logic [ByteW-1:0] RST_MAX_LEN  = 8'd8;

  localparam logic [ByteW-1:0] CSUM_BASE = 8'hFF;

  typedef struct packed {
    logic [ByteW-1:0] ack_code;
    logic [ByteW-1:0] ack_data_code;
    logic [ByteW-1:0] nack_code;
    logic [ByteW-1:0] ack_error_code;
    logic [ByteW-1:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CodeW-1:0]  frame_kind;
    logic [CodeW-1:0]  frame_status;
    logic [ValueW-1:0] payload_value;
    logic [ByteW-1:0]  payload_length;
  } result_t;

endpackage

>>> rtl/rfp_cfg.sv
module rfp_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rfp_pkg::IdxW-1:0]  cfg_index,
  input  logic [rfp_pkg::ByteW-1:0] cfg_wdata,
  output rfp_pkg::cfg_t             cfg
);

  rfp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_code        <= rfp_pkg::RST_ACK;
      cfg_r.ack_data_code   <= rfp_pkg::RST_ACK_DATA;
      cfg_r.nack_code       <= rfp_pkg::RST_NACK;
      cfg_r.ack_error_code  <= rfp_pkg::RST_ACK_ERR;
      cfg_r.max_frame_bytes <= rfp_pkg::RST_MAX_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfp_pkg::REG_ACK:      cfg_r.ack_code        <= cfg_wdata;
        rfp_pkg::REG_ACK_DATA: cfg_r.ack_data_code   <= cfg_wdata;
        rfp_pkg::REG_NACK:     cfg_r.nack_code       <= cfg_wdata;
        rfp_pkg::REG_ACK_ERR:  cfg_r.ack_error_code  <= cfg_wdata;
        rfp_pkg::REG_MAX_LEN:  cfg_r.max_frame_bytes <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/rfp_parser.sv
module rfp_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [rfp_pkg::ByteW-1:0] in_byte,
  input  rfp_pkg::cfg_t             cfg,
  output rfp_pkg::result_t          res
);

  logic [rfp_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [rfp_pkg::ByteW-1:0]  decl_len_r, decl_len_nxt;
  logic [rfp_pkg::ByteW-1:0]  left_r, left_nxt;
  logic [rfp_pkg::ByteW-1:0]  sum_r, sum_nxt;
  logic [rfp_pkg::ValueW-1:0] acc_r, acc_nxt;
  logic [rfp_pkg::ByteW-1:0]  expect_sum;
  logic                       too_long;

  assign expect_sum = rfp_pkg::CSUM_BASE - sum_r;
  assign too_long   = ({1'b0, in_byte} + 9'd3) > {1'b0, cfg.max_frame_bytes};

  always_comb begin
    phase_nxt          = phase_r;
    decl_len_nxt       = decl_len_r;
    left_nxt           = left_r;
    sum_nxt            = sum_r;
    acc_nxt            = acc_r;
    res                = '0;
    if (in_fire) begin
      unique case (phase_r)
        rfp_pkg::PH_LEN: begin
          decl_len_nxt = in_byte;
          sum_nxt      = sum_r + in_byte;
          acc_nxt      = '0;
          if (too_long) begin
            res.valid          = 1'b1;
            res.frame_kind     = rfp_pkg::KIND_DATA;
            res.frame_status   = rfp_pkg::ST_LONG;
            res.payload_length = in_byte;
            phase_nxt          = rfp_pkg::PH_IDLE;
          end else begin
            left_nxt  = in_byte;
            phase_nxt = (in_byte == '0) ? rfp_pkg::PH_DATA_CSUM : rfp_pkg::PH_DATA;
          end
        end
        rfp_pkg::PH_DATA: begin
          acc_nxt  = {acc_r[rfp_pkg::ValueW-rfp_pkg::ByteW-1:0], in_byte};
          sum_nxt  = sum_r + in_byte;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            phase_nxt = rfp_pkg::PH_DATA_CSUM;
          end
        end
        rfp_pkg::PH_DATA_CSUM: begin
          res.valid          = 1'b1;
          res.frame_kind     = rfp_pkg::KIND_DATA;
          res.frame_status   = (in_byte == expect_sum) ? rfp_pkg::ST_OK : rfp_pkg::ST_CSUM;
          res.payload_value  = acc_r;
          res.payload_length = decl_len_r;
          phase_nxt          = rfp_pkg::PH_IDLE;
        end
        rfp_pkg::PH_ERR_BYTE: begin
          acc_nxt   = {{(rfp_pkg::ValueW-rfp_pkg::ByteW){1'b0}}, in_byte};
          sum_nxt   = sum_r + in_byte;
          phase_nxt = rfp_pkg::PH_ERR_CSUM;
        end
        rfp_pkg::PH_ERR_CSUM: begin
          res.valid          = 1'b1;
          res.frame_kind     = rfp_pkg::KIND_ERR;
          res.frame_status   = (in_byte == expect_sum) ? rfp_pkg::ST_OK : rfp_pkg::ST_CSUM;
          res.payload_value  = acc_r;
          phase_nxt          = rfp_pkg::PH_IDLE;
        end
        default: begin
          // type byte
          phase_nxt    = rfp_pkg::PH_IDLE;
          sum_nxt      = in_byte;
          decl_len_nxt = '0;
          left_nxt     = '0;
          acc_nxt      = '0;
          if (in_byte == cfg.ack_code) begin
            res.valid      = 1'b1;
            res.frame_kind = rfp_pkg::KIND_ACK;
          end else if (in_byte == cfg.ack_data_code) begin
            phase_nxt = rfp_pkg::PH_LEN;
          end else if (in_byte == cfg.nack_code) begin
            res.valid      = 1'b1;
            res.frame_kind = rfp_pkg::KIND_NACK;
          end else if (in_byte == cfg.ack_error_code) begin
            if (cfg.max_frame_bytes < 8'd3) begin
              res.valid        = 1'b1;
              res.frame_kind   = rfp_pkg::KIND_ERR;
              res.frame_status = rfp_pkg::ST_LONG;
            end else begin
              phase_nxt = rfp_pkg::PH_ERR_BYTE;
            end
          end else begin
            res.valid        = 1'b1;
            res.frame_kind   = rfp_pkg::KIND_ACK;
            res.frame_status = rfp_pkg::ST_UNKNOWN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rfp_pkg::PH_IDLE;
      decl_len_r <= '0;
      left_r     <= '0;
      sum_r      <= '0;
      acc_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      decl_len_r <= decl_len_nxt;
      left_r     <= left_nxt;
      sum_r      <= sum_nxt;
      acc_r      <= acc_nxt;
    end
  end

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rfp_pkg::PH_DATA) |-> (left_r != '0))
    else $error("data phase with no bytes left");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (phase_r == rfp_pkg::PH_IDLE))
    else $error("parser not idle after a result");

  a_no_fire_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(phase_r) && $stable(sum_r) && $stable(acc_r))
    else $error("parser state moved without a request");

endmodule

>>> rtl/rfp_out_stage.sv
module rfp_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rfp_pkg::result_t          res,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  output logic [rfp_pkg::DataW-1:0] out_tdata,
  output logic [rfp_pkg::CodeW-1:0] out_tuser,
  output logic                      room
);

  logic                      valid_r, valid_nxt;
  logic [rfp_pkg::DataW-1:0] data_r;
  logic [rfp_pkg::CodeW-1:0] user_r;

  assign room = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= {6'd0, res.payload_length, res.payload_value, res.frame_status};
      user_r <= res.frame_kind;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |-> !res.valid)
    else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> valid_r)
    else $error("loaded result not shown");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_tready && !res.valid) |=> !valid_r)
    else $error("taken result not cleared");

endmodule

>>> rtl/response_frame_parser_unit.sv
// output: a result appears on out_* in the cycle after the frame's last byte is accepted
// throughput: one byte accepted per cycle, held back only while a result waits on out_tready
// the output register lets the next byte enter in the cycle the pending result is taken
// reset: rst_n synchronous active low; parser returns to idle awaiting a type byte
// registers return to their defaults and any pending result is dropped
module response_frame_parser_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // rx_byte[7:0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rfp_pkg::DataW-1:0] out_tdata,  // frame_status[1:0], payload_value[33:2],
                                                // payload_length[41:34], zero fill
  output logic [1:0]                out_tuser,  // frame_kind[1:0]
  input  logic                      cfg_we,
  input  logic [rfp_pkg::IdxW-1:0]  cfg_index,
  input  logic [7:0]                cfg_wdata
);

  rfp_pkg::cfg_t    cfg;
  rfp_pkg::result_t res;
  logic             room;
  logic             in_fire;

  assign in_tready = room;
  assign in_fire   = in_tvalid && room;

  rfp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  rfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .room       (room)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rfp_pkg::*;

  localparam int NumPhases  = 6;
  localparam int PhaseBytes = 85;
  localparam int CycleLimit = 400000;
  localparam int DirRows    = 26;

  typedef struct packed {
    logic [ByteW-1:0]  rx;
    logic              typed;
    logic [CodeW-1:0]  kind;
    logic [CodeW-1:0]  status;
    logic [ValueW-1:0] value;
    logic [ByteW-1:0]  len;
  } stim_row_t;

  // hand-checked rows carry their result, the rest go through the frame predictor
  stim_row_t dir_rows [DirRows] = '{
    '{8'h06, 1'b1, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h15, 1'b1, KIND_NACK, ST_OK,      32'd0, 8'd0},
    '{8'h00, 1'b1, KIND_ACK,  ST_UNKNOWN, 32'd0, 8'd0},
    '{8'h07, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h04, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h12, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h34, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h56, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h78, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'hE0, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h07, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h00, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'hF8, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h07, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h06, 1'b1, KIND_DATA, ST_LONG,    32'd0, 8'd6},
    '{8'h07, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h05, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'hFF, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h00, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'hAA, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h55, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h01, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h00, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h08, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'hA5, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0},
    '{8'h52, 1'b0, KIND_ACK,  ST_OK,      32'd0, 8'd0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [DataW-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             cfg_we = 1'b0;
  logic [IdxW-1:0]  cfg_index = '0;
  logic [7:0]       cfg_wdata = '0;

  response_frame_parser_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // frame predictor state
  cfg_t              regs = '{RST_ACK, RST_ACK_DATA, RST_NACK, RST_ACK_ERR, RST_MAX_LEN};
  logic [PhaseW-1:0] parse_state = PH_IDLE;
  logic [ByteW-1:0]  decl_len = '0;
  logic [ByteW-1:0]  left_cnt = '0;
  logic [ByteW-1:0]  run_sum = '0;
  logic [ValueW-1:0] value_acc = '0;

  result_t frames_due[$];
  int      bytes_sent = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      cycle_cnt = 0;

  function automatic result_t frame_result(input logic [CodeW-1:0] kind,
                                           input logic [CodeW-1:0] status,
                                           input logic [ValueW-1:0] value,
                                           input logic [ByteW-1:0] len);
    result_t r;
    r.valid          = 1'b1;
    r.frame_kind     = kind;
    r.frame_status   = status;
    r.payload_value  = value;
    r.payload_length = len;
    return r;
  endfunction

  function automatic result_t parse_byte(input logic [ByteW-1:0] b);
    result_t          r;
    logic [ByteW-1:0] want;
    r = '0;
    want = CSUM_BASE - run_sum;
    case (parse_state)
      PH_LEN: begin
        decl_len  = b;
        run_sum   = run_sum + b;
        value_acc = '0;
        if (int'(b) + 3 > int'(regs.max_frame_bytes)) begin
          r = frame_result(KIND_DATA, ST_LONG, '0, b);
          parse_state = PH_IDLE;
        end else begin
          left_cnt = b;
          parse_state = (b == 0) ? PH_DATA_CSUM : PH_DATA;
        end
      end
      PH_DATA: begin
        value_acc = {value_acc[ValueW-ByteW-1:0], b};
        run_sum   = run_sum + b;
        left_cnt  = left_cnt - 8'd1;
        if (left_cnt == 0) parse_state = PH_DATA_CSUM;
      end
      PH_DATA_CSUM: begin
        r = frame_result(KIND_DATA, (b == want) ? ST_OK : ST_CSUM, value_acc, decl_len);
        parse_state = PH_IDLE;
      end
      PH_ERR_BYTE: begin
        value_acc = {{(ValueW-ByteW){1'b0}}, b};
        run_sum   = run_sum + b;
        parse_state = PH_ERR_CSUM;
      end
      PH_ERR_CSUM: begin
        r = frame_result(KIND_ERR, (b == want) ? ST_OK : ST_CSUM, value_acc, '0);
        parse_state = PH_IDLE;
      end
      default: begin
        // type byte, first matching code wins
        parse_state = PH_IDLE;
        run_sum   = b;
        decl_len  = '0;
        left_cnt  = '0;
        value_acc = '0;
        if (b == regs.ack_code) begin
          r = frame_result(KIND_ACK, ST_OK, '0, '0);
        end else if (b == regs.ack_data_code) begin
          parse_state = PH_LEN;
        end else if (b == regs.nack_code) begin
          r = frame_result(KIND_NACK, ST_OK, '0, '0);
        end else if (b == regs.ack_error_code) begin
          if (regs.max_frame_bytes < 3) r = frame_result(KIND_ERR, ST_LONG, '0, '0);
          else parse_state = PH_ERR_BYTE;
        end else begin
          r = frame_result(KIND_ACK, ST_UNKNOWN, '0, '0);
        end
      end
    endcase
    return r;
  endfunction

  function automatic int idle_mode();
    return (bytes_sent < 180) ? 0 : ((bytes_sent < 360) ? 1 : 2);
  endfunction

  function automatic bit sender_idles();
    case (idle_mode())
      0:       return $urandom_range(0, 99) < 22;
      1:       return $urandom_range(0, 99) < 86;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_ready();
    case (idle_mode())
      0:       return $urandom_range(0, 99) >= 86;
      1:       return $urandom_range(0, 99) >= 22;
      default: return 1'b1;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result();
    result_t           want;
    logic [CodeW-1:0]  kind;
    logic [CodeW-1:0]  status;
    logic [ValueW-1:0] value;
    logic [ByteW-1:0]  len;
    kind   = out_tuser;
    status = out_tdata[1:0];
    value  = out_tdata[33:2];
    len    = out_tdata[41:34];
    results_seen++;
    if (frames_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d status %0d value 0x%08h",
                                kind, status, value));
      return;
    end
    want = frames_due.pop_front();
    if (kind !== want.frame_kind)
      report_mismatch($sformatf("result %0d frame_kind %0d, expected %0d",
                                results_seen, kind, want.frame_kind));
    if (status !== want.frame_status)
      report_mismatch($sformatf("result %0d frame_status %0d, expected %0d",
                                results_seen, status, want.frame_status));
    if (value !== want.payload_value)
      report_mismatch($sformatf("result %0d payload_value 0x%08h, expected 0x%08h",
                                results_seen, value, want.payload_value));
    if (len !== want.payload_length)
      report_mismatch($sformatf("result %0d payload_length %0d, expected %0d",
                                results_seen, len, want.payload_length));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    out_tready <= receiver_ready();
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, frames_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic deliver(input logic [ByteW-1:0] b);
    while (sender_idles()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    result_t r;
    deliver(b);
    r = parse_byte(b);
    if (r.valid) frames_due.push_back(r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ACK:      regs.ack_code        = val;
      REG_ACK_DATA: regs.ack_data_code   = val;
      REG_NACK:     regs.nack_code       = val;
      REG_ACK_ERR:  regs.ack_error_code  = val;
      REG_MAX_LEN:  regs.max_frame_bytes = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t s);
    set_reg(REG_ACK, s.ack_code);
    set_reg(REG_ACK_DATA, s.ack_data_code);
    set_reg(REG_NACK, s.nack_code);
    set_reg(REG_ACK_ERR, s.ack_error_code);
    set_reg(REG_MAX_LEN, s.max_frame_bytes);
    // index past the register list must be ignored
    set_reg(IdxW'($urandom_range(int'(REG_MAX_LEN) + 1, (1 << IdxW) - 1)), 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t phase_settings(input int p);
    cfg_t s;
    s = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(3, 20))};
    case (p)
      1: s = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
      2: s = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'd3};
      3: s = '{8'h41, 8'h42, 8'h43, 8'h44, 8'd2};
      5: s.max_frame_bytes = 8'($urandom_range(3, 255));
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_frame();
    int               pick;
    int               len_max;
    int               n;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] sum;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_byte(8'($urandom));
    end else if (pick < 30) begin
      send_byte(regs.ack_code);
    end else if (pick < 45) begin
      send_byte(regs.nack_code);
    end else if (pick < 80) begin
      len_max = int'(regs.max_frame_bytes) - 3;
      if (len_max > 6) len_max = 6;
      if (len_max < 0 || $urandom_range(0, 15) == 0) n = $urandom_range(0, 255);
      else n = $urandom_range(0, len_max);
      sum = regs.ack_data_code + 8'(n);
      send_byte(regs.ack_data_code);
      send_byte(8'(n));
      if (n + 3 > int'(regs.max_frame_bytes)) return;
      for (int i = 0; i < n; i++) begin
        // truncated frame now and then
        if (i > 0 && $urandom_range(0, 49) == 0) return;
        b = 8'($urandom);
        sum = sum + b;
        send_byte(b);
      end
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : CSUM_BASE - sum);
    end else begin
      sum = regs.ack_error_code;
      send_byte(regs.ack_error_code);
      if (regs.max_frame_bytes < 3) return;
      b = 8'($urandom);
      sum = sum + b;
      send_byte(b);
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : CSUM_BASE - sum);
    end
  endtask

  initial begin
    int      frames;
    int      start;
    result_t r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain();
        repeat (3) @(posedge clk);
        apply_settings(phase_settings(p));
      end else begin
        foreach (dir_rows[k]) begin
          deliver(dir_rows[k].rx);
          r = parse_byte(dir_rows[k].rx);
          if (dir_rows[k].typed)
            frames_due.push_back(frame_result(dir_rows[k].kind, dir_rows[k].status,
                                              dir_rows[k].value, dir_rows[k].len));
          else if (r.valid)
            frames_due.push_back(r);
        end
      end
      frames = 0;
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
        send_frame();
        frames++;
        if (frames % 25 == 0) drain();
      end
      // close any open frame before touching the registers
      while (parse_state != PH_IDLE) send_byte(8'($urandom));
    end

    drain();
    repeat (5) @(posedge clk);
    $display("sent %0d bytes under %0d register settings, checked %0d frame results",
             bytes_sent, NumPhases, results_seen);
    $display("frames covered: ack, nack, data, error, unknown type, too long, bad checksum");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
